// ===== src/dynamic_hash_bucket_locator_top_defines.svh =====
// Assertion macros used by the RTL of the bucket locator top module.
`ifndef DYNAMIC_HASH_BUCKET_LOCATOR_TOP_DEFINES_SVH
`define DYNAMIC_HASH_BUCKET_LOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHBL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dhbl assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DHBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dhbl assertion failed");

`endif

// ===== src/dhbl_pkg.sv =====
`default_nettype none

package dhbl_pkg;

   localparam int unsigned HASH_W  = 32;
   localparam int unsigned LEVEL_W = 12;
   localparam int unsigned POS_W   = 13;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 12'hFFF;

   localparam logic [1:0] REQ_KEY_BYTE = 2'd0;
   localparam logic [1:0] REQ_LOCATE   = 2'd1;
   localparam logic [1:0] REQ_SPLIT    = 2'd2;

   localparam logic [1:0] STATUS_LOCATED   = 2'd0;
   localparam logic [1:0] STATUS_SPLIT     = 2'd1;
   localparam logic [1:0] STATUS_DENIED    = 2'd2;
   localparam logic [1:0] STATUS_BEYOND    = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ABSORB_HI,
      ST_WALK_ISSUE,
      ST_WALK_WAIT
   } state_type;

   typedef struct packed {
      logic       absorb;
      logic [3:0] nibble;
      logic       clear;
   } hash_ctl_type;

   localparam logic [5:0] STEP_TAB [16] = '{
      6'd61, 6'd57, 6'd53, 6'd49, 6'd45, 6'd41, 6'd37, 6'd33,
      6'd29, 6'd25, 6'd21, 6'd17, 6'd13, 6'd9,  6'd5,  6'd1
   };

   localparam logic [31:0] SUM_TAB [64] = '{
      32'o6100151277, 32'o6106161736, 32'o6452611562, 32'o5001724107,
      32'o2614772546, 32'o4120731531, 32'o4665262210, 32'o7347467531,
      32'o6735253126, 32'o6042345173, 32'o3072226605, 32'o1464164730,
      32'o3247435524, 32'o7652510057, 32'o1546775256, 32'o5714532133,
      32'o6173260402, 32'o7517101630, 32'o2431460343, 32'o1743245566,
      32'o0261675137, 32'o2433103631, 32'o3421772437, 32'o4447707466,
      32'o4435620103, 32'o3757017115, 32'o3641531772, 32'o6767633246,
      32'o2673230344, 32'o0260612216, 32'o4133454451, 32'o0615531516,
      32'o6137717526, 32'o2574116560, 32'o2304023373, 32'o7061702261,
      32'o5153031405, 32'o5322056705, 32'o7401116734, 32'o6552375715,
      32'o6165233473, 32'o5311063631, 32'o1212221723, 32'o1052267235,
      32'o6000615237, 32'o1075222665, 32'o6330216006, 32'o4402355630,
      32'o1451177262, 32'o2000133436, 32'o6025467062, 32'o7121076461,
      32'o3123433522, 32'o1010635225, 32'o1716177066, 32'o5161746527,
      32'o1736635071, 32'o6243505026, 32'o3637211610, 32'o1756474365,
      32'o4723077174, 32'o3642763134, 32'o5750130273, 32'o3655541561
   };

endpackage

`default_nettype wire

// ===== src/dynamic_hash_bucket_locator_top.sv =====
// Channel   Handshake                 Payload
// req       start / busy              req_type, req_key_byte, req_last, req_hash_in
// rsp       rsp_valid (strobe)        rsp_bucket, rsp_level_mask, rsp_hash_value, rsp_status
// csr       csr_valid / csr_ready     csr_read_only
//
// A key byte: low nibble when accepted, high in ST_ABSORB_HI, then idle or, if last, a locate.
// A locate reads the bitmap level by level, each in an issue state and then a wait on the
// RAM; a stop at the widest mask or past the map ends in an issue state without a read.
// A split is done on acceptance in ST_IDLE; each result is on the rsp ports the cycle after it is formed.
// After reset the bitmap RAM is cleared one bit per cycle, all DIR_BITS positions, with busy high.
// The receiver cannot stall; csr_ready is always high.
`default_nettype none

`include "dynamic_hash_bucket_locator_top_defines.svh"

module dynamic_hash_bucket_locator_top #(
   parameter int unsigned DIR_BITS = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_key_byte,
   input  wire logic        req_last,
   input  wire logic [31:0] req_hash_in,
   output logic             rsp_valid,
   output logic [11:0]      rsp_bucket,
   output logic [11:0]      rsp_level_mask,
   output logic [31:0]      rsp_hash_value,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_read_only
);

   localparam int unsigned AW        = $clog2(DIR_BITS);
   localparam logic [31:0] DIR_LIMIT = 32'(DIR_BITS);
   localparam logic [AW-1:0] CLEAR_LAST = AW'(DIR_BITS - 1);

   dhbl_pkg::state_type state_ff, state_in;

   logic [31:0]                  h_ff, h_in;
   logic [11:0]                  mask_ff, mask_in;
   logic [dhbl_pkg::POS_W-1:0]   last_pos_ff, last_pos_in;
   logic [3:0]                   byte_hi_ff, byte_hi_in;
   logic                         last_ff, last_in;
   logic [AW-1:0]                clear_cnt_ff, clear_cnt_in;
   logic                         read_only_ff, read_only_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [11:0]                  rsp_bucket_ff, rsp_bucket_in;
   logic [11:0]                  rsp_mask_ff, rsp_mask_in;
   logic [31:0]                  rsp_hash_ff, rsp_hash_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;

   logic                         ram_wr_en;
   logic [AW-1:0]                ram_wr_addr;
   logic [0:0]                   ram_wr_data;
   logic                         ram_rd_en;
   logic [AW-1:0]                ram_rd_addr;
   logic [0:0]                   ram_rd_data;

   dhbl_pkg::hash_ctl_type       hash_ctl;
   logic [31:0]                  hash_next;

   logic                         accept;
   logic [dhbl_pkg::POS_W-1:0]   walk_pos;
   logic                         walk_off_map;

   dhbl_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .ctl      (hash_ctl),
      .sum_next (hash_next)
   );

   // One bit per directory position. A set bit means that bucket has been split.
   dhbl_ram #(
      .WIDTH (1),
      .DEPTH (DIR_BITS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy      = (state_ff != dhbl_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Position of the bit tested at the current level: bucket plus mask.
   assign walk_pos     = {1'b0, h_ff[11:0] & mask_ff} + {1'b0, mask_ff};
   assign walk_off_map = ({19'd0, walk_pos} >= DIR_LIMIT);

   always_comb begin
      state_in      = state_ff;
      h_in          = h_ff;
      mask_in       = mask_ff;
      last_pos_in   = last_pos_ff;
      byte_hi_in    = byte_hi_ff;
      last_in       = last_ff;
      clear_cnt_in  = clear_cnt_ff;
      read_only_in  = csr_valid ? csr_read_only : read_only_ff;

      rsp_valid_in  = 1'b0;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_status_in = rsp_status_ff;

      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(last_pos_ff);
      ram_wr_data   = 1'b1;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(walk_pos);

      hash_ctl.absorb = 1'b0;
      hash_ctl.nibble = req_key_byte[3:0];
      hash_ctl.clear  = 1'b0;

      case (state_ff)
         dhbl_pkg::ST_CLEAR: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = clear_cnt_ff;
            ram_wr_data  = 1'b0;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == CLEAR_LAST) begin
               state_in = dhbl_pkg::ST_IDLE;
            end
         end
         dhbl_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  dhbl_pkg::REQ_KEY_BYTE: begin
                     // Low nibble goes in now, the high one next cycle.
                     hash_ctl.absorb = 1'b1;
                     byte_hi_in      = req_key_byte[7:4];
                     last_in         = req_last;
                     state_in        = dhbl_pkg::ST_ABSORB_HI;
                  end
                  dhbl_pkg::REQ_LOCATE: begin
                     h_in     = req_hash_in;
                     mask_in  = '0;
                     state_in = dhbl_pkg::ST_WALK_ISSUE;
                  end
                  dhbl_pkg::REQ_SPLIT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_bucket_in = '0;
                     rsp_mask_in   = '0;
                     rsp_hash_in   = '0;
                     if (read_only_ff) begin
                        rsp_status_in = dhbl_pkg::STATUS_DENIED;
                     end else if (({19'd0, last_pos_ff} >= DIR_LIMIT) ||
                                  (last_pos_ff >= {1'b0, dhbl_pkg::LEVEL_TOP})) begin
                        rsp_status_in = dhbl_pkg::STATUS_BEYOND;
                     end else begin
                        ram_wr_en     = 1'b1;
                        rsp_status_in = dhbl_pkg::STATUS_SPLIT;
                     end
                  end
                  default: begin
                     // The unused request type is dropped.
                  end
               endcase
            end
         end
         dhbl_pkg::ST_ABSORB_HI: begin
            hash_ctl.absorb = 1'b1;
            hash_ctl.nibble = byte_hi_ff;
            hash_ctl.clear  = last_ff;
            if (last_ff) begin
               h_in     = hash_next;
               mask_in  = '0;
               state_in = dhbl_pkg::ST_WALK_ISSUE;
            end else begin
               state_in = dhbl_pkg::ST_IDLE;
            end
         end
         dhbl_pkg::ST_WALK_ISSUE: begin
            last_pos_in = walk_pos;
            // The top level and positions past the map end the walk without a read.
            if ((mask_ff == dhbl_pkg::LEVEL_TOP) || walk_off_map) begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = h_ff[11:0] & mask_ff;
               rsp_mask_in   = mask_ff;
               rsp_hash_in   = h_ff;
               rsp_status_in = dhbl_pkg::STATUS_LOCATED;
               state_in      = dhbl_pkg::ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = dhbl_pkg::ST_WALK_WAIT;
            end
         end
         dhbl_pkg::ST_WALK_WAIT: begin
            if (ram_rd_data[0]) begin
               mask_in  = {mask_ff[10:0], 1'b1};
               state_in = dhbl_pkg::ST_WALK_ISSUE;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_bucket_in = h_ff[11:0] & mask_ff;
               rsp_mask_in   = mask_ff;
               rsp_hash_in   = h_ff;
               rsp_status_in = dhbl_pkg::STATUS_LOCATED;
               state_in      = dhbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dhbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dhbl_pkg::ST_CLEAR;
         clear_cnt_ff <= '0;
         read_only_ff <= 1'b0;
         last_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         read_only_ff <= read_only_in;
         last_pos_ff  <= last_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff          <= h_in;
      mask_ff       <= mask_in;
      byte_hi_ff    <= byte_hi_in;
      last_ff       <= last_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_level_mask = rsp_mask_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign rsp_status     = rsp_status_ff;

   // The reported bucket never has bits outside the level mask.
   `DHBL_ASSERT_SAME(a_bucket_in_mask, clock, reset, rsp_valid, (rsp_bucket & ~rsp_level_mask) == 12'd0)
   // The level mask is always a run of ones from bit zero.
   `DHBL_ASSERT_SAME(a_mask_shape, clock, reset, rsp_valid, (rsp_level_mask & (rsp_level_mask + 12'd1)) == 12'd0)
   // A bitmap read is always followed by the wait for its data.
   `DHBL_ASSERT_NEXT(a_read_then_wait, clock, reset, ram_rd_en, state_ff == dhbl_pkg::ST_WALK_WAIT)
   // Outside the clearing pass a bitmap write sets a bit and only when writable.
   `DHBL_ASSERT_SAME(a_split_write, clock, reset, ram_wr_en && (state_ff != dhbl_pkg::ST_CLEAR), !read_only_ff && ram_wr_data[0])

endmodule

`default_nettype wire

// ===== src/dhbl_ram.sv =====
`default_nettype none

module dhbl_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/dhbl_hash.sv =====
`default_nettype none

// Running key hash: one nibble per cycle while ctl.absorb is set, through the step and sum tables.
module dhbl_hash (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dhbl_pkg::hash_ctl_type    ctl,
   output logic [dhbl_pkg::HASH_W-1:0]    sum_next
);

   logic [5:0]                  index_ff;
   logic [5:0]                  index_in;
   logic [dhbl_pkg::HASH_W-1:0] sum_ff;
   logic [dhbl_pkg::HASH_W-1:0] sum_in;

   always_comb begin
      index_in = index_ff + dhbl_pkg::STEP_TAB[ctl.nibble];
      sum_in   = sum_ff + dhbl_pkg::SUM_TAB[index_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         sum_ff   <= '0;
      end else if (ctl.absorb) begin
         if (ctl.clear) begin
            index_ff <= '0;
            sum_ff   <= '0;
         end else begin
            index_ff <= index_in;
            sum_ff   <= sum_in;
         end
      end
   end

   assign sum_next = sum_in;

endmodule

`default_nettype wire
